FILE: sv/ilp_pkg.sv
// Integer list text parser: shared widths, character codes and seen-map geometry.
// No dependencies; compiled first and imported by the interfaces and the top level.
`default_nettype none

package ilp_pkg;

	// Number range: every accepted number lies below ID_COUNT
	localparam int unsigned ID_COUNT    = 1024;
	localparam int unsigned IDX_W       = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	// Room for the largest accepted number times ten plus a digit
	localparam int unsigned ACC_W       = $clog2(ID_COUNT * 10);
	localparam int unsigned DEC_BASE    = 10;

	// Field widths of the channels
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned INDEX_OUT_W = 10;

	// Seen map: rows of ROW_W flags, one valid bit per row (at most 256 rows)
	localparam int unsigned ROW_W  = (ID_COUNT <= 8192) ? 32 :
	                                 (1 << $clog2((ID_COUNT + 255) / 256));
	localparam int unsigned BIT_W  = $clog2(ROW_W);
	localparam int unsigned ROWS   = ((1 << IDX_W) + ROW_W - 1) / ROW_W;
	localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Character codes
	localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

FILE: sv/ilp_if.sv
// Integer list text parser: valid/ready channel interfaces for text bytes and results.
// Depends on ilp_pkg for field widths.
`default_nettype none

interface ilp_in_if
	import ilp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ilp_out_if
	import ilp_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic                   index_valid;
	logic [INDEX_OUT_W-1:0] index_value;
	logic                   finished;
	logic                   well_formed;

	modport source (output valid, output index_valid, output index_value,
	                output finished, output well_formed, input ready);
	modport sink   (input valid, input index_valid, input index_value,
	                input finished, input well_formed, output ready);
endinterface

`default_nettype wire

FILE: sv/ilp_ram.sv
// Integer list text parser: generic single write port RAM with registered read.
// No dependencies.
`default_nettype none

module ilp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                        wdata,
	input  wire                                     re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: sv/integer_list_text_parser_unit.sv
// Integer list text parser: top level, byte register, parse logic, seen map, result register.
// Depends on ilp_pkg, ilp_in_if / ilp_out_if and ilp_ram.
//
//   port    | dir | transfer carries
//   --------+-----+-----------------------------------------------------
//   chars   | in  | text_byte, last_byte: one character of the list
//   result  | out | index_valid, index_value, finished, well_formed
//
// One byte per cycle sustained while results are taken; a result enters the result register
// from the byte register when that register advances, and can then transfer. The seen
// map is a RAM of rows read as each byte is taken, at the row that byte will need, so the
// parse step never waits on it.
// Reset and every byte marked last clear the row valid bits at once: no clearing pass.
// A stalled result holds the byte register; new bytes are taken while it drains.
`default_nettype none

module integer_list_text_parser_unit
	import ilp_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	ilp_in_if.sink       chars,
	ilp_out_if.source    result
);
	typedef enum logic [6:0] {
		PH_BEFORE_OPEN = 7'b0000001,
		PH_AFTER_OPEN  = 7'b0000010,
		PH_EXPECT_NUM  = 7'b0000100,
		PH_IN_NUM      = 7'b0001000,
		PH_AFTER_NUM   = 7'b0010000,
		PH_TAIL        = 7'b0100000,
		PH_ERROR       = 7'b1000000
	} ilp_phase_t;

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [BYTE_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Value after taking a digit: continue the number or start a new one
	function automatic logic [ACC_W-1:0] digit_value(input logic in_num,
			input logic [IDX_W-1:0] acc, input logic [BYTE_W-1:0] c);
		logic [ACC_W-1:0] base;
		base = in_num ? ACC_W'(acc) * ACC_W'(DEC_BASE) : '0;
		return base + ACC_W'(c[3:0]);
	endfunction

	// Number whose seen flag this byte may need
	function automatic logic [ACC_W-1:0] check_value(input logic in_num,
			input logic [IDX_W-1:0] acc, input logic [BYTE_W-1:0] c);
		return is_digit(c) ? digit_value(in_num, acc, c) : ACC_W'(acc);
	endfunction

	function automatic ilp_phase_t after_number(input logic [BYTE_W-1:0] c);
		ilp_phase_t ph;
		if (c == CH_COMMA) begin
			ph = PH_EXPECT_NUM;
		end else if (c == CH_CLOSE) begin
			ph = PH_TAIL;
		end else if (is_blank(c)) begin
			ph = PH_AFTER_NUM;
		end else begin
			ph = PH_ERROR;
		end
		return ph;
	endfunction

	// Byte register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Parse state
	ilp_phase_t        phase_q;
	logic [IDX_W-1:0]  acc_q;
	logic [ROWS-1:0]   row_vld_q;
	logic              byp_q;
	logic [ROW_W-1:0]  byp_row_q;

	// Result register
	logic                   out_valid_q;
	logic                   out_index_valid_q;
	logic [INDEX_OUT_W-1:0] out_index_value_q;
	logic                   out_finished_q;
	logic                   out_well_formed_q;

	// Step logic
	logic              adv;
	logic              in_fire;
	logic              dig;
	logic [ACC_W-1:0]  acc_dig;
	logic              dig_ok;
	logic [ACC_W-1:0]  chk;
	logic [ROW_AW-1:0] chk_row;
	logic [BIT_W-1:0]  chk_bit;
	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  seen_row;
	logic              seen;
	ilp_phase_t        phase_n;
	logic [IDX_W-1:0]  acc_n;
	logic              idx_vld;
	logic [IDX_W-1:0]  idx_val;
	logic              wf;
	logic              wr;
	logic              wr_en;
	logic [ROW_AW-1:0] wr_row;
	logic [ROW_W-1:0]  wr_data;
	ilp_phase_t        phase_eff;
	logic [IDX_W-1:0]  acc_eff;
	logic [ACC_W-1:0]  pre_chk;
	logic [ROW_AW-1:0] pre_row;

	// Handshake: the byte register advances whenever the result register frees up
	assign adv          = valid_s1 && (!out_valid_q || result.ready);
	assign chars.ready  = !valid_s1 || adv;
	assign in_fire      = chars.valid && chars.ready;

	// Seen flag for the number this byte checks, with the same-edge write folded in
	assign dig      = is_digit(byte_s1);
	assign acc_dig  = digit_value(phase_q == PH_IN_NUM, acc_q, byte_s1);
	assign dig_ok   = acc_dig < ACC_W'(ID_COUNT);
	assign chk      = check_value(phase_q == PH_IN_NUM, acc_q, byte_s1);
	assign chk_row  = ROW_AW'(IDX_W'(chk) >> BIT_W);
	assign chk_bit  = BIT_W'(IDX_W'(chk));
	assign seen_row = row_vld_q[chk_row] ? (byp_q ? byp_row_q : rd_row) : '0;
	assign seen     = seen_row[chk_bit];

	// Parse one byte
	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		idx_vld = 1'b0;
		idx_val = '0;
		wr      = 1'b0;
		case (phase_q)
			PH_BEFORE_OPEN: begin
				if (byte_s1 == CH_OPEN) begin
					phase_n = PH_AFTER_OPEN;
				end else if (!is_blank(byte_s1)) begin
					phase_n = PH_ERROR;
				end
			end
			PH_AFTER_OPEN, PH_EXPECT_NUM: begin
				if (dig) begin
					acc_n   = IDX_W'(acc_dig);
					phase_n = dig_ok ? PH_IN_NUM : PH_ERROR;
				end else if (byte_s1 == CH_CLOSE && phase_q == PH_AFTER_OPEN) begin
					phase_n = PH_TAIL;
				end else if (!is_blank(byte_s1)) begin
					phase_n = PH_ERROR;
				end
			end
			PH_IN_NUM: begin
				if (dig) begin
					if (dig_ok) begin
						acc_n = IDX_W'(acc_dig);
					end else begin
						acc_n   = '0;
						phase_n = PH_ERROR;
					end
				end else if (seen) begin
					phase_n = PH_ERROR;
				end else begin
					// number ends: report it, then treat the byte as after a number
					idx_vld = 1'b1;
					idx_val = acc_q;
					wr      = !last_s1;
					phase_n = after_number(byte_s1);
				end
			end
			PH_AFTER_NUM: begin
				phase_n = after_number(byte_s1);
			end
			PH_TAIL: begin
				if (!is_blank(byte_s1)) begin
					phase_n = PH_ERROR;
				end
			end
			default: begin
				phase_n = PH_ERROR;
			end
		endcase

		// String ends inside a number: complete it, reject the list
		if (last_s1 && phase_n == PH_IN_NUM) begin
			idx_vld = !seen;
			idx_val = acc_n;
			phase_n = PH_ERROR;
		end
		wf = last_s1 && (phase_n == PH_TAIL);
	end

	// Seen map update: set the flag of a new number
	assign wr_en   = adv && wr;
	assign wr_row  = ROW_AW'(acc_q >> BIT_W);
	assign wr_data = seen_row | (ROW_W'(1) << chk_bit);

	// Prefetch the row the incoming byte will check, from the state it will see
	assign phase_eff = adv ? (last_s1 ? PH_BEFORE_OPEN : phase_n) : phase_q;
	assign acc_eff   = adv ? acc_n : acc_q;
	assign pre_chk   = check_value(phase_eff == PH_IN_NUM, acc_eff, chars.text_byte);
	assign pre_row   = ROW_AW'(IDX_W'(pre_chk) >> BIT_W);

	ilp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_seen_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_data),
		.re    (in_fire),
		.raddr (pre_row),
		.rdata (rd_row)
	);

	// Byte register: load on transfer, drop once consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= chars.text_byte;
			last_s1 <= chars.last_byte;
		end
	end

	// Parse state: advance per byte, clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_BEFORE_OPEN;
			acc_q     <= '0;
			row_vld_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q   <= PH_BEFORE_OPEN;
				acc_q     <= '0;
				row_vld_q <= '0;
			end else begin
				phase_q <= phase_n;
				acc_q   <= acc_n;
				if (wr) begin
					row_vld_q[wr_row] <= 1'b1;
				end
			end
		end
	end

	// Bypass: a row written on the edge it is read comes from here, not the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (in_fire) begin
			byp_q <= wr_en && (wr_row == pre_row);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byp_row_q <= wr_data;
		end
	end

	// Result register: load on advance, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_index_valid_q <= idx_vld;
			out_index_value_q <= idx_vld ? INDEX_OUT_W'(idx_val) : '0;
			out_finished_q    <= last_s1;
			out_well_formed_q <= wf;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.index_valid = out_index_valid_q;
	assign result.index_value = out_index_value_q;
	assign result.finished    = out_finished_q;
	assign result.well_formed = out_well_formed_q;
endmodule

`default_nettype wire
